// ----- src/pcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcd_pkg
// shared types and constants of the prefix code decoder
// ---------------------------------------------------------------------------
package pcd_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int MAX_CODE_LEN_DEF  = 32;

    // bit position of the first code bit in a data byte
    localparam int BYTE_MSB = 7;
    localparam int BYTE_W   = BYTE_MSB + 1;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_DECODE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_DECODE,
        CMD_CLEAR
    } cmd_kind_t;

    // one classified word from the front to the back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  idx;
        logic [7:0]  sym;
        logic [31:0] code;
        logic [5:0]  len;
        logic [7:0]  data;
        logic [3:0]  cnt;
        logic        eos;
    } cmd_t;

endpackage : pcd_pkg
`default_nettype wire

// ----- src/pcd_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcd_in_if
// input channel: one load, decode or clear word
// ---------------------------------------------------------------------------
interface pcd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  entry_index;
    logic [7:0]  entry_symbol;
    logic [31:0] entry_code;
    logic [5:0]  entry_length;
    logic [7:0]  data_byte;
    logic [3:0]  valid_bits;
    logic        end_of_stream;

    modport source (
        output valid, action, entry_index, entry_symbol, entry_code,
               entry_length, data_byte, valid_bits, end_of_stream,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, entry_symbol, entry_code,
               entry_length, data_byte, valid_bits, end_of_stream,
        output ready
    );
endinterface : pcd_in_if
`default_nettype wire

// ----- src/pcd_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcd_out_if
// output channel: one decoded symbol or error word
// ---------------------------------------------------------------------------
interface pcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       overflow_error;
    logic       last_of_run;

    modport source (
        output valid, symbol, overflow_error, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, symbol, overflow_error, last_of_run,
        output ready
    );
endinterface : pcd_out_if
`default_nettype wire

// ----- src/pcd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcd_front
// accepts input words, classifies them and queues them for the back end
// ---------------------------------------------------------------------------
module pcd_front #(
    parameter int TABLE_ENTRIES = pcd_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    pcd_in_if.sink             din,
    output pcd_pkg::cmd_t      cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_pop
);
    import pcd_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       q_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cmd_new;
    logic       keep;
    logic       push;
    logic       pop;

    assign din.ready = (cnt_reg != 2'(DEPTH));

    always_comb
    begin
        cmd_new.kind = CMD_DECODE;
        cmd_new.idx  = din.entry_index;
        cmd_new.sym  = din.entry_symbol;
        cmd_new.code = din.entry_code;
        cmd_new.len  = din.entry_length;
        cmd_new.data = din.data_byte;
        cmd_new.cnt  = (din.valid_bits > 4'(BYTE_W)) ? 4'(BYTE_W) : din.valid_bits;
        cmd_new.eos  = din.end_of_stream;
        keep         = 1'b0;
        case (din.action)
            ACT_LOAD:
            begin
                cmd_new.kind = CMD_LOAD;
                keep = (9'(din.entry_index) < 9'(TABLE_ENTRIES));
            end
            ACT_DECODE:
            begin
                cmd_new.kind = CMD_DECODE;
                keep = 1'b1;
            end
            ACT_CLEAR:
            begin
                cmd_new.kind = CMD_CLEAR;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push      = din.valid && din.ready && keep;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule : pcd_front
`default_nettype wire

// ----- src/pcd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pcd_back
// code table, bit-serial table search and result output register
// ---------------------------------------------------------------------------
module pcd_back #(
    parameter int TABLE_ENTRIES = pcd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_LEN  = pcd_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pcd_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_pop,
    pcd_out_if.source          dout
);
    import pcd_pkg::*;

    localparam int IDX_W  = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PW     = MAX_CODE_LEN;
    localparam int PLEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int CW     = (PW > 32) ? PW : 32;
    localparam int LW     = (PLEN_W > 6) ? PLEN_W : 6;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_SCAN,
        S_RES,
        S_END
    } state_t;

    typedef struct packed {
        logic [7:0]  sym;
        logic [31:0] code;
        logic [5:0]  len;
    } slot_t;

    slot_t slot_mem [TABLE_ENTRIES];

    state_t                   state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] vld_reg, vld_next;
    logic [PW-1:0]            pend_reg, pend_next;
    logic [PLEN_W-1:0]        plen_reg, plen_next;
    logic [7:0]               byte_reg, byte_next;
    logic [3:0]               cnt_reg, cnt_next;
    logic [3:0]               bit_reg, bit_next;
    logic                     eos_reg, eos_next;
    logic [IDX_W-1:0]         scan_reg, scan_next;
    logic                     done_reg, done_next;
    logic                     chk_reg, chk_next;
    logic                     chk_last_reg, chk_last_next;
    logic                     held_reg, held_next;
    logic                     out_vld_reg, out_vld_next;

    slot_t      rd_reg;
    logic       rd_ok_reg;
    logic [7:0] res_sym_reg, res_sym_next;
    logic       res_err_reg, res_err_next;
    logic [7:0] held_sym_reg, held_sym_next;
    logic       held_err_reg, held_err_next;
    logic [7:0] out_sym_reg, out_sym_next;
    logic       out_err_reg, out_err_next;
    logic       out_last_reg, out_last_next;

    logic mem_we;
    logic hit;
    logic out_free;

    assign out_free = !out_vld_reg || dout.ready;
    assign hit = chk_reg && rd_ok_reg
               && (LW'(plen_reg) == LW'(rd_reg.len))
               && (CW'(pend_reg) == CW'(rd_reg.code));

    always_comb
    begin
        state_next    = state_reg;
        vld_next      = vld_reg;
        pend_next     = pend_reg;
        plen_next     = plen_reg;
        byte_next     = byte_reg;
        cnt_next      = cnt_reg;
        bit_next      = bit_reg;
        eos_next      = eos_reg;
        scan_next     = scan_reg;
        done_next     = done_reg;
        chk_next      = chk_reg;
        chk_last_next = chk_last_reg;
        held_next     = held_reg;
        res_sym_next  = res_sym_reg;
        res_err_next  = res_err_reg;
        held_sym_next = held_sym_reg;
        held_err_next = held_err_reg;
        out_vld_next  = out_vld_reg && !dout.ready;
        out_sym_next  = out_sym_reg;
        out_err_next  = out_err_reg;
        out_last_next = out_last_reg;
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_LOAD:
                        begin
                            mem_we = 1'b1;
                            vld_next[cmd.idx[IDX_W-1:0]] = (cmd.len != 6'd0);
                        end
                        CMD_CLEAR:
                        begin
                            vld_next  = '0;
                            pend_next = '0;
                            plen_next = '0;
                        end
                        CMD_DECODE:
                        begin
                            byte_next  = cmd.data;
                            cnt_next   = cmd.cnt;
                            eos_next   = cmd.eos;
                            bit_next   = 4'd0;
                            state_next = S_NEXT;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_NEXT:
            begin
                if (bit_reg == cnt_reg)
                begin
                    state_next = S_END;
                end
                else
                begin
                    // append the next code bit and restart the table search
                    pend_next  = {pend_reg[PW-2:0], byte_reg[BYTE_MSB]};
                    byte_next  = {byte_reg[BYTE_MSB-1:0], 1'b0};
                    plen_next  = plen_reg + 1'b1;
                    scan_next  = '0;
                    done_next  = 1'b0;
                    chk_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    res_sym_next = rd_reg.sym;
                    res_err_next = 1'b0;
                    chk_next     = 1'b0;
                    state_next   = S_RES;
                end
                else if (chk_reg && chk_last_reg)
                begin
                    chk_next = 1'b0;
                    if (plen_reg == PLEN_W'(MAX_CODE_LEN))
                    begin
                        res_sym_next = 8'd0;
                        res_err_next = 1'b1;
                        state_next   = S_RES;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 4'd1;
                        state_next = S_NEXT;
                    end
                end
                else if (!done_reg)
                begin
                    chk_next      = 1'b1;
                    chk_last_next = (scan_reg == LAST_IDX);
                    done_next     = (scan_reg == LAST_IDX);
                    scan_next     = scan_reg + 1'b1;
                end
                else
                begin
                    chk_next = 1'b0;
                end
            end
            S_RES:
            begin
                // the held result goes out once a newer one exists, or in S_END at the byte's end
                if (!held_reg || out_free)
                begin
                    if (held_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_sym_next  = held_sym_reg;
                        out_err_next  = held_err_reg;
                        out_last_next = 1'b0;
                    end
                    held_next     = 1'b1;
                    held_sym_next = res_sym_reg;
                    held_err_next = res_err_reg;
                    pend_next     = '0;
                    plen_next     = '0;
                    bit_next      = bit_reg + 4'd1;
                    state_next    = S_NEXT;
                end
            end
            S_END:
            begin
                if (!held_reg || out_free)
                begin
                    if (held_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_sym_next  = held_sym_reg;
                        out_err_next  = held_err_reg;
                        out_last_next = 1'b1;
                        held_next     = 1'b0;
                    end
                    if (eos_reg)
                    begin
                        pend_next = '0;
                        plen_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            vld_reg      <= '0;
            pend_reg     <= '0;
            plen_reg     <= '0;
            bit_reg      <= 4'd0;
            cnt_reg      <= 4'd0;
            eos_reg      <= 1'b0;
            scan_reg     <= '0;
            done_reg     <= 1'b0;
            chk_reg      <= 1'b0;
            chk_last_reg <= 1'b0;
            held_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            vld_reg      <= vld_next;
            pend_reg     <= pend_next;
            plen_reg     <= plen_next;
            bit_reg      <= bit_next;
            cnt_reg      <= cnt_next;
            eos_reg      <= eos_next;
            scan_reg     <= scan_next;
            done_reg     <= done_next;
            chk_reg      <= chk_next;
            chk_last_reg <= chk_last_next;
            held_reg     <= held_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        res_sym_reg  <= res_sym_next;
        res_err_reg  <= res_err_next;
        held_sym_reg <= held_sym_next;
        held_err_reg <= held_err_next;
        out_sym_reg  <= out_sym_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    // code table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[cmd.idx[IDX_W-1:0]] <= '{sym: cmd.sym, code: cmd.code, len: cmd.len};
        end
        rd_reg    <= slot_mem[scan_reg];
        rd_ok_reg <= vld_reg[scan_reg];
    end

    assign dout.valid          = out_vld_reg;
    assign dout.symbol         = out_sym_reg;
    assign dout.overflow_error = out_err_reg;
    assign dout.last_of_run    = out_last_reg;

endmodule : pcd_back
`default_nettype wire

// ----- src/prefix_code_bit_serial_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prefix_code_bit_serial_decoder
// bit-serial decoder for a table-driven variable-length prefix code
// ---------------------------------------------------------------------------
//  channel | dir | word carried
//  --------+-----+------------------------------------------------------
//  din     | in  | load table slot, decode one byte, or clear everything
//  dout    | out | decoded symbol or overflow error, last flag per byte
//
//  load and clear words are handled in the idle state of the back end; a decode
//  word takes one search per consumed bit, walking the table one slot a cycle
//  through the registered read port and stopping at the first match
//  reset empties the table (valid flags) and the pending code at once
//  a two-word queue decouples front and back; a stalled dout holds the back end
// ---------------------------------------------------------------------------
module prefix_code_bit_serial_decoder #(
    parameter int TABLE_ENTRIES = pcd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_LEN  = pcd_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pcd_in_if.sink    din,
    pcd_out_if.source dout
);
    import pcd_pkg::*;

    // classified word at the head of the queue
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    // front: classify, drop unused actions and out-of-range slots, queue
    pcd_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // back: table writes, bit-by-bit search, result register
    pcd_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_LEN  (MAX_CODE_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .dout      (dout)
    );

endmodule : prefix_code_bit_serial_decoder
`default_nettype wire

// ----- tb/sv/tb_scoreboard.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_scoreboard
// predicts decoded symbols and overflow errors, checks every output word
// ---------------------------------------------------------------------------
package tb_scoreboard_pkg;
    import pcd_pkg::*;

    typedef struct packed {
        logic [7:0] symbol;
        logic       overflow_error;
        logic       last_of_run;
    } sym_word_t;

    class sym_scoreboard;
        bit          slot_valid [256];
        logic [7:0]  slot_sym [256];
        logic [31:0] slot_code [256];
        logic [5:0]  slot_len [256];
        logic [63:0] code_acc;
        int unsigned code_len;
        sym_word_t   pending_syms [$];
        int          errors;

        function void clear_all();
            foreach (slot_valid[k])
                slot_valid[k] = 0;
            code_acc = '0;
            code_len = 0;
        endfunction

        function new();
            errors = 0;
            clear_all();
        endfunction

        // lowest slot whose code equals the pending code, or -1
        function int lookup();
            for (int k = 0; k < 256; k++)
                if (slot_valid[k] && slot_len[k] == code_len
                    && {32'd0, slot_code[k]} == code_acc)
                    return k;
            return -1;
        endfunction

        function void note_word(logic [1:0] act, logic [7:0] idx, logic [7:0] sym,
                                logic [31:0] code, logic [5:0] len, logic [7:0] data,
                                logic [3:0] cnt, logic eos);
            int unsigned n;
            int hit;
            int first;
            sym_word_t w;
            first = pending_syms.size();
            if (act == ACT_LOAD) begin
                slot_sym[idx] = sym;
                slot_code[idx] = code;
                slot_len[idx] = len;
                slot_valid[idx] = (len != 0);
            end else if (act == ACT_CLEAR) begin
                clear_all();
            end else if (act == ACT_DECODE) begin
                n = (cnt > 8) ? 8 : cnt;
                for (int i = 0; i < n; i++) begin
                    code_acc = {code_acc[62:0], data[BYTE_MSB - i]};
                    code_len++;
                    hit = lookup();
                    if (hit >= 0) begin
                        w = '{slot_sym[hit], 1'b0, 1'b0};
                        pending_syms.push_back(w);
                        code_acc = '0;
                        code_len = 0;
                    end else if (code_len >= MAX_CODE_LEN_DEF) begin
                        w = '{8'd0, 1'b1, 1'b0};
                        pending_syms.push_back(w);
                        code_acc = '0;
                        code_len = 0;
                    end
                end
                if (eos) begin
                    code_acc = '0;
                    code_len = 0;
                end
                if (pending_syms.size() > first)
                    pending_syms[pending_syms.size() - 1].last_of_run = 1'b1;
            end
        endfunction

        function void check_word(sym_word_t got);
            sym_word_t exp;
            if (pending_syms.size() == 0) begin
                $error("unexpected output word %p", got);
                errors++;
                return;
            end
            exp = pending_syms.pop_front();
            if (got.symbol !== exp.symbol) begin
                $error("symbol expected %0d actual %0d", exp.symbol, got.symbol);
                errors++;
            end
            if (got.overflow_error !== exp.overflow_error) begin
                $error("overflow_error expected %0b actual %0b",
                       exp.overflow_error, got.overflow_error);
                errors++;
            end
            if (got.last_of_run !== exp.last_of_run) begin
                $error("last_of_run expected %0b actual %0b",
                       exp.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction
    endclass
endpackage : tb_scoreboard_pkg

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// drives load, decode and clear words into the prefix code decoder and checks
// every decoded symbol and overflow error against a local prediction
// ---------------------------------------------------------------------------
module tb;
    import pcd_pkg::*;
    import tb_scoreboard_pkg::*;

    // a search may walk the whole table for each of the eight bits
    localparam int SLOW_CYCLES = 8 * (TABLE_ENTRIES_DEF + 3);
    localparam int WATCHDOG    = 40 * SLOW_CYCLES;

    logic clk;
    logic rst_n;

    pcd_in_if  din ();
    pcd_out_if dout ();

    prefix_code_bit_serial_decoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din.sink),
        .dout  (dout.source)
    );

    sym_scoreboard sb;
    bit            calm;      // no idling in the last part of the run
    int            stall_cnt;
    int            quiet_cycles;

    // small code set used for well-formed streams: codes and lengths
    logic [31:0] code_bits [8];
    logic [5:0]  code_lens [8];

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    // output side: random stall bursts, check on every accepted word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout.ready <= 1'b0;
            stall_cnt  <= 0;
        end
        else
        begin
            if (dout.valid && dout.ready)
                sb.check_word('{dout.symbol, dout.overflow_error, dout.last_of_run});
            if (stall_cnt > 0)
            begin
                stall_cnt  <= stall_cnt - 1;
                dout.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_cnt  <= $urandom_range(1, 11) - 1;
                dout.ready <= 1'b0;
            end
            else
                dout.ready <= 1'b1;
        end
    end

    // watchdog: cycles with no word accepted on either channel
    always @(posedge clk)
    begin
        if ((din.valid && din.ready) || (dout.valid && dout.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one word on din, held until accepted, then noted for prediction;
    // valid stays high so a following word can go out back to back
    task automatic send_word(logic [1:0] act, logic [7:0] idx, logic [7:0] sym,
                             logic [31:0] code, logic [5:0] len, logic [7:0] data,
                             logic [3:0] cnt, logic eos);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din.valid         <= 1'b1;
        din.action        <= act;
        din.entry_index   <= idx;
        din.entry_symbol  <= sym;
        din.entry_code    <= code;
        din.entry_length  <= len;
        din.data_byte     <= data;
        din.valid_bits    <= cnt;
        din.end_of_stream <= eos;
        do
            @(posedge clk);
        while (!(din.valid && din.ready));
        sb.note_word(act, idx, sym, code, len, data, cnt, eos);
    endtask

    task automatic load_slot(int idx, int sym, logic [31:0] code, int len);
        send_word(ACT_LOAD, 8'(idx), 8'(sym), code, 6'(len), 8'($urandom),
                  4'($urandom), 1'($urandom));
    endtask

    task automatic decode_byte(logic [7:0] data, logic [3:0] cnt, logic eos);
        send_word(ACT_DECODE, 8'($urandom), 8'($urandom), $urandom, 6'($urandom),
                  data, cnt, eos);
    endtask

    // sender holds off until every predicted word has come out
    task automatic drain();
        din.valid <= 1'b0;
        while (sb.pending_syms.size() != 0)
            @(posedge clk);
        repeat (4 * SLOW_CYCLES) @(posedge clk);
    endtask

    // a prefix-free code set: 0, 10, 110, 1110, 11110, 111110, 1111110, 1111111
    task automatic load_code_set();
        for (int k = 0; k < 8; k++)
        begin
            code_lens[k] = 6'((k == 7) ? 7 : k + 1);
            code_bits[k] = (k == 7) ? 32'h7F : ((32'h1 << (k + 1)) - 2);
            load_slot(k + $urandom_range(0, 1) * 100, $urandom, code_bits[k], code_lens[k]);
        end
    endtask

    // random symbols packed into bytes of the loaded code set
    task automatic send_stream(int nbytes);
        logic [63:0] acc;
        int          fill;
        int          s;
        acc  = '0;
        fill = 0;
        for (int b = 0; b < nbytes; b++)
        begin
            while (fill < 8)
            begin
                s    = $urandom_range(0, 7);
                acc  = (acc << code_lens[s]) | code_bits[s];
                fill = fill + code_lens[s];
            end
            decode_byte(8'(acc >> (fill - 8)),
                        4'((b == nbytes - 1) ? $urandom_range(1, 8) : 8),
                        b == nbytes - 1);
            fill = fill - 8;
            acc  = acc & ((64'd1 << fill) - 1);
        end
    endtask

    initial
    begin
        int ops;
        sb        = new();
        calm      = 0;
        din.valid = 1'b0;
        din.action = ACT_LOAD;
        din.entry_index = '0;
        din.entry_symbol = '0;
        din.entry_code = '0;
        din.entry_length = '0;
        din.data_byte = '0;
        din.valid_bits = '0;
        din.end_of_stream = 1'b0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table runs into overflow after 32 bits
        for (int i = 0; i < 4; i++)
            decode_byte(8'hFF, 4'd8, 1'b0);
        // full-length 32-bit code, codes above 32 bits, duplicate in a higher slot
        load_slot(255, 8'hFF, 32'hFFFF_FFFF, 32);
        load_slot(3, 8'h00, 32'h0, 6'd63);
        load_slot(4, 8'hA5, 32'h1, 6'd33);
        load_slot(0, 8'h11, 32'h5, 3);
        load_slot(1, 8'h22, 32'h5, 3);
        load_slot(2, 8'h33, 32'h0, 0);
        decode_byte(8'hA0, 4'd3, 1'b0);
        for (int i = 0; i < 4; i++)
            decode_byte(8'hFF, 4'd8, 1'b0);
        // valid_bits zero and above eight, end flag dropping leftovers
        decode_byte(8'h80, 4'd0, 1'b1);
        decode_byte(8'hA0, 4'd15, 1'b1);
        decode_byte(8'h40, 4'd2, 1'b1);
        // unused action, then clear
        send_word(2'd3, 8'd0, 8'd0, 32'd0, 6'd0, 8'hFF, 4'd8, 1'b0);
        drain();
        send_word(ACT_CLEAR, 8'd0, 8'd0, 32'd0, 6'd0, 8'h00, 4'd0, 1'b0);
        decode_byte(8'hA0, 4'd3, 1'b1);

        // random: mostly well-formed streams, some noise
        ops = 0;
        while (ops < 420)
        begin
            if (ops > 360)
                calm = 1;
            case ($urandom_range(0, 9))
                0:
                begin
                    send_word(ACT_CLEAR, 8'($urandom), 8'($urandom), $urandom,
                              6'($urandom), 8'($urandom), 4'($urandom), 1'($urandom));
                    load_code_set();
                    ops += 9;
                end
                1:
                begin
                    load_slot($urandom, $urandom, $urandom, $urandom_range(0, 63));
                    ops++;
                end
                2:
                begin
                    send_word(2'($urandom), 8'($urandom), 8'($urandom), $urandom,
                              6'($urandom), 8'($urandom), 4'($urandom), 1'($urandom));
                    ops++;
                end
                3:
                begin
                    decode_byte(8'($urandom), 4'($urandom), 1'($urandom));
                    ops++;
                end
                default:
                begin
                    if (ops < 10)
                        load_code_set();
                    send_stream($urandom_range(1, 6));
                    ops += 3;
                end
            endcase
            if (ops > 200 && ops < 215)
                drain();
        end

        drain();
        if (sb.errors == 0 && sb.pending_syms.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule : tb

// ----- files.f -----
src/pcd_pkg.sv
src/pcd_in_if.sv
src/pcd_out_if.sv
src/pcd_front.sv
src/pcd_back.sv
src/prefix_code_bit_serial_decoder.sv
tb/sv/tb_scoreboard.sv
tb/sv/tb.sv
